[sv/grdm_pkg.sv]
// Shared types, constants and elaboration-time sine table math for the grid ray marcher.
package grdm_pkg;

    // Default parameter values.
    localparam int GRID_SIZE_DEF  = 16;
    localparam int MAX_STEPS_DEF  = 32;
    localparam int ANGLE_BITS_DEF = 10;

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Trig value width: signed Q1.14, magnitude up to 16384.
    localparam int TRIG_W = 16;
    localparam int MAG_W  = 15;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_WALL_0      = 3'd2,
        REG_WALL_1      = 3'd3,
        REG_WALL_2      = 3'd4,
        REG_WALL_3      = 3'd5
    } cfg_reg_t;

    // Why the march stopped.
    typedef enum logic [1:0] {
        END_LEFT_MAP   = 2'd0,
        END_WALL_HIT   = 2'd1,
        END_STEP_LIMIT = 2'd2
    } end_reason_t;

    // Sequencer commands to the march unit.
    typedef struct packed {
        logic load_pos;
        logic load_dx;
        logic load_dy;
        logic advance;
    } march_ctl_t;

    // March unit status, valid from the current position registers.
    typedef struct packed {
        logic        stop;
        end_reason_t reason;
        logic [3:0]  row;
        logic [3:0]  col;
    } march_stat_t;

    // pi/2 in Q60.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

    // Taylor divisors (2n)(2n+1) for n = 1 to 12.
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // (a * b) >> 60 kept to 64 bits; used only while building the table.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // round(16384 * sin(pi/2 * r / 2^qtr_bits)), evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned qtr_bits);
        logic [63:0] part;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        part = HALF_PI_Q60 & ((64'd1 << qtr_bits) - 64'd1);
        x    = (HALF_PI_Q60 >> qtr_bits) * 64'(r) + ((part * 64'(r)) >> qtr_bits);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++)
        begin
            term = mul_q60(term, x2) / TAYLOR_DIV[n];
            if (n % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return MAG_W'((sum + (64'd1 << 45)) >> 46);
    endfunction

endpackage

[sv/grid_ray_march_distance.sv]
// Top level of the grid ray marcher: config registers, sequencer, distance multiply, output word.
//
// Usage: an input word (start_x, start_y, view_angle, ray_angle) is taken when in_valid is
// high and in_stall is low. The block then runs one ray on its own and offers one result word
// (corrected_distance, step_count, end_reason, stop_row, stop_column) on out_valid; the word
// is taken when out_valid is high and out_stall is low.
// After the input word is taken, states S_COS, S_SIN and S_CORR fetch cos and sin of the ray
// angle and the cosine of view minus ray from one shared quarter-wave ROM, the march then tests
// one cell per cycle in S_MARCH, S_MULT multiplies, and S_DONE loads the output register.
// Throughput: one ray at a time.
// in_stall is low only while the sequencer is idle. A finished word waits in the output
// register while out_stall is high, and the next ray may already be accepted and marched;
// its result is held back until the output register is free.
// Reset clears the sequencer and out_valid and restores width 10, height 10 and an empty
// wall map. Registers are written over the APB port at byte address 8 * index, and should
// only be written while no ray is in flight.
module grid_ray_march_distance #(
    parameter int GRID_SIZE  = grdm_pkg::GRID_SIZE_DEF,
    parameter int MAX_STEPS  = grdm_pkg::MAX_STEPS_DEF,
    parameter int ANGLE_BITS = grdm_pkg::ANGLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [grdm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [grdm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [grdm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [15:0]                         start_x,
    input  logic [15:0]                         start_y,
    input  logic [ANGLE_BITS-1:0]               view_angle,
    input  logic [ANGLE_BITS-1:0]               ray_angle,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [16:0]                  corrected_distance,
    output logic [5:0]                          step_count,
    output logic [1:0]                          end_reason,
    output logic [3:0]                          stop_row,
    output logic [3:0]                          stop_column
);
    import grdm_pkg::*;

    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int PROD_W  = TRIG_W + STEP_W + 1;
    localparam logic [ANGLE_BITS-1:0] QTR_ANGLE = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    localparam logic signed [PROD_W-1:0] DIST_MAX = PROD_W'(65535);
    localparam logic signed [PROD_W-1:0] DIST_MIN = PROD_W'(-65536);
    localparam logic [5:0] STEP_SAT = (MAX_STEPS > 63) ? 6'd63 : 6'(MAX_STEPS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COS   = 7'b0000010,
        S_SIN   = 7'b0000100,
        S_CORR  = 7'b0001000,
        S_MARCH = 7'b0010000,
        S_MULT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [4:0]  width_reg;
    logic [4:0]  height_reg;
    logic [63:0] wall_reg [4];

    logic [ANGLE_BITS-1:0] view_reg;
    logic [ANGLE_BITS-1:0] ray_reg;
    logic [ANGLE_BITS-1:0] trig_angle;
    logic signed [TRIG_W-1:0] trig_val;

    march_ctl_t            march_ctl;
    march_stat_t           march_stat;
    logic [STEP_W-1:0]     march_steps;
    logic [255:0]          wall_map;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] dist_shift;
    logic signed [16:0]       dist_sat;
    logic [6:0]               steps_wide;
    logic                     in_accept;
    logic                     out_free;
    logic                     cfg_write;

    logic                 out_valid_reg;
    logic signed [16:0]   dist_reg;
    logic [5:0]           steps_out_reg;
    end_reason_t          reason_reg;
    logic [3:0]           row_reg;
    logic [3:0]           col_reg;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 5'd10;
            height_reg  <= 5'd10;
            wall_reg[0] <= '0;
            wall_reg[1] <= '0;
            wall_reg[2] <= '0;
            wall_reg[3] <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                REG_GRID_WIDTH:  width_reg   <= pwdata[4:0];
                REG_GRID_HEIGHT: height_reg  <= pwdata[4:0];
                REG_WALL_0:      wall_reg[0] <= pwdata;
                REG_WALL_1:      wall_reg[1] <= pwdata;
                REG_WALL_2:      wall_reg[2] <= pwdata;
                REG_WALL_3:      wall_reg[3] <= pwdata;
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[5:3])
            REG_GRID_WIDTH:  prdata = 64'(width_reg);
            REG_GRID_HEIGHT: prdata = 64'(height_reg);
            REG_WALL_0:      prdata = wall_reg[0];
            REG_WALL_1:      prdata = wall_reg[1];
            REG_WALL_2:      prdata = wall_reg[2];
            REG_WALL_3:      prdata = wall_reg[3];
            default:         prdata = '0;
        endcase
    end

    assign wall_map = {wall_reg[3], wall_reg[2], wall_reg[1], wall_reg[0]};

    // Handshakes.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_COS;
                end
            end
            S_COS:   state_next = S_SIN;
            S_SIN:   state_next = S_CORR;
            S_CORR:  state_next = S_MARCH;
            S_MARCH:
            begin
                if (march_stat.stop)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Angles of the accepted word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            view_reg <= view_angle;
            ray_reg  <= ray_angle;
        end
    end

    // One ROM serves cos(ray), sin(ray) and cos(view - ray) in turn.
    always_comb
    begin
        case (state_reg)
            S_COS:   trig_angle = ray_reg + QTR_ANGLE;
            S_SIN:   trig_angle = ray_reg;
            default: trig_angle = view_reg - ray_reg + QTR_ANGLE;
        endcase
    end

    grdm_trig #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_trig (
        .clk   (clk),
        .angle (trig_angle),
        .value (trig_val)
    );

    // March commands; the ROM word arrives in the cycle after its angle.
    assign march_ctl.load_pos = in_accept;
    assign march_ctl.load_dx  = (state_reg == S_SIN);
    assign march_ctl.load_dy  = (state_reg == S_CORR);
    assign march_ctl.advance  = (state_reg == S_MARCH);

    grdm_march #(
        .GRID_SIZE (GRID_SIZE),
        .MAX_STEPS (MAX_STEPS)
    ) u_march (
        .clk         (clk),
        .ctl         (march_ctl),
        .start_x     (start_x),
        .start_y     (start_y),
        .trig_val    (trig_val),
        .grid_width  (width_reg),
        .grid_height (height_reg),
        .wall_map    (wall_map),
        .stat        (march_stat),
        .steps       (march_steps)
    );

    // Steps times the view correction cosine, still on the ROM output.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MULT)
        begin
            prod_reg <= PROD_W'($signed({1'b0, march_steps})) * PROD_W'(trig_val);
        end
    end

    // Floor shift to Q.10 and clamp to the 17-bit range.
    assign dist_shift = prod_reg >>> 4;
    always_comb
    begin
        if (dist_shift > DIST_MAX)
        begin
            dist_sat = 17'(DIST_MAX);
        end
        else if (dist_shift < DIST_MIN)
        begin
            dist_sat = 17'(DIST_MIN);
        end
        else
        begin
            dist_sat = dist_shift[16:0];
        end
    end

    assign steps_wide = 7'(march_steps);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            dist_reg      <= dist_sat;
            steps_out_reg <= (steps_wide > 7'd63) ? 6'd63 : steps_wide[5:0];
            reason_reg    <= march_stat.reason;
            row_reg       <= march_stat.row;
            col_reg       <= march_stat.col;
        end
    end

    assign out_valid          = out_valid_reg;
    assign corrected_distance = dist_reg;
    assign step_count         = steps_out_reg;
    assign end_reason         = reason_reg;
    assign stop_row           = row_reg;
    assign stop_column        = col_reg;

    // A new result word appears only when the sequencer finishes a ray.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result word appeared without a finished ray");

    // Accepting a word closes the input until the ray is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input stayed open after accepting a word");

    // Cell coordinates are reported only for a wall hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_reason != END_WALL_HIT |-> stop_row == 4'd0 && stop_column == 4'd0)
        else $error("stop cell reported for a ray that hit no wall");

    // A ray stopped by the step limit took every allowed step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_reason == END_STEP_LIMIT |-> step_count == STEP_SAT)
        else $error("step limit reported with a short step count");

endmodule

[sv/grdm_trig.sv]
// Shared sine/cosine lookup: quarter-wave ROM with registered read and sign fix-up.
module grdm_trig #(
    parameter int ANGLE_BITS = grdm_pkg::ANGLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic [ANGLE_BITS-1:0]           angle,
    output logic signed [grdm_pkg::TRIG_W-1:0] value
);
    import grdm_pkg::*;

    localparam int QTR_BITS = ANGLE_BITS - 2;
    localparam int QTR      = 1 << QTR_BITS;
    localparam int ROM_AW   = QTR_BITS + 1;
    localparam logic [ROM_AW-1:0] QTR_ADDR = ROM_AW'(QTR);

    typedef logic [MAG_W-1:0] rom_t [0:QTR];

    // Table of round(16384 * sin) over one quarter turn, ends included.
    function automatic rom_t build_rom();
        rom_t tbl;
        for (int i = 0; i <= QTR; i++)
        begin
            tbl[i] = quarter_sine(i, QTR_BITS);
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]          quadrant;
    logic [QTR_BITS-1:0] offset;
    logic [ROM_AW-1:0]   rom_addr;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_reg;

    // Fold the angle into the first quadrant.
    assign quadrant = angle[ANGLE_BITS-1 -: 2];
    assign offset   = angle[QTR_BITS-1:0];
    assign rom_addr = quadrant[0] ? (QTR_ADDR - {1'b0, offset}) : {1'b0, offset};

    // Registered ROM read; the lower half-turn is negated.
    always_ff @(posedge clk)
    begin
        mag_reg <= SINE_ROM[rom_addr];
        neg_reg <= quadrant[1];
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

[sv/grdm_march.sv]
// Position accumulator with bounds, wall and step-limit tests; one step per cycle while advance is set.
module grdm_march #(
    parameter int GRID_SIZE = grdm_pkg::GRID_SIZE_DEF,
    parameter int MAX_STEPS = grdm_pkg::MAX_STEPS_DEF
) (
    input  logic                               clk,
    input  grdm_pkg::march_ctl_t               ctl,
    input  logic [15:0]                        start_x,
    input  logic [15:0]                        start_y,
    input  logic signed [grdm_pkg::TRIG_W-1:0] trig_val,
    input  logic [4:0]                         grid_width,
    input  logic [4:0]                         grid_height,
    input  logic [255:0]                       wall_map,
    output grdm_pkg::march_stat_t              stat,
    output logic [$clog2(MAX_STEPS+1)-1:0]     steps
);
    import grdm_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int POS_W  = 16 + $clog2(MAX_STEPS);
    localparam int CELL_W = POS_W - 13;
    localparam int DIR_W  = TRIG_W - 2;
    localparam logic [4:0]        GRID_LIM  = 5'(GRID_SIZE);
    localparam logic [STEP_W-1:0] STEP_LIM  = STEP_W'(MAX_STEPS);

    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic signed [DIR_W-1:0] dx_reg;
    logic signed [DIR_W-1:0] dy_reg;
    logic [STEP_W-1:0]       steps_reg;

    logic [4:0]       w_eff;
    logic [4:0]       h_eff;
    logic             outside;
    logic             wall_hit;
    logic             at_limit;
    logic [3:0]       row;
    logic [3:0]       col;

    // Bounds clipped to the map size.
    assign w_eff = (grid_width  > GRID_LIM) ? GRID_LIM : grid_width;
    assign h_eff = (grid_height > GRID_LIM) ? GRID_LIM : grid_height;

    // Tests on the current position, in priority order.
    assign outside  = x_reg[POS_W-1] || y_reg[POS_W-1]
                   || (x_reg[POS_W-2:12] >= CELL_W'(w_eff))
                   || (y_reg[POS_W-2:12] >= CELL_W'(h_eff));
    assign row      = x_reg[15:12];
    assign col      = y_reg[15:12];
    assign wall_hit = wall_map[{row, col}];
    assign at_limit = steps_reg >= STEP_LIM;

    always_comb
    begin
        stat.stop   = outside || wall_hit || at_limit;
        stat.row    = 4'd0;
        stat.col    = 4'd0;
        if (outside)
        begin
            stat.reason = END_LEFT_MAP;
        end
        else if (wall_hit)
        begin
            stat.reason = END_WALL_HIT;
            stat.row    = row;
            stat.col    = col;
        end
        else if (at_limit)
        begin
            stat.reason = END_STEP_LIMIT;
        end
        else
        begin
            stat.reason = END_LEFT_MAP;
        end
    end

    // Load the start and direction, then add the direction once per step.
    always_ff @(posedge clk)
    begin
        if (ctl.load_pos)
        begin
            x_reg     <= POS_W'(start_x);
            y_reg     <= POS_W'(start_y);
            steps_reg <= '0;
        end
        else if (ctl.advance && !stat.stop)
        begin
            x_reg     <= x_reg + POS_W'(dx_reg);
            y_reg     <= y_reg + POS_W'(dy_reg);
            steps_reg <= steps_reg + STEP_W'(1);
        end
        if (ctl.load_dx)
        begin
            dx_reg <= trig_val[TRIG_W-1:2];
        end
        if (ctl.load_dy)
        begin
            dy_reg <= trig_val[TRIG_W-1:2];
        end
    end

    assign steps = steps_reg;

endmodule

[bench/grid_ray_march_distance_tb.sv]
// Self-checking testbench for the grid ray marcher: directed and random rays against a local model.
module grid_ray_march_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grdm_pkg::*;

    localparam int GRID_CELLS   = 16;
    localparam int STEP_LIMIT   = 32;
    localparam int ANGLE_W      = 10;
    localparam int QUARTER      = 256;
    localparam int MAX_IDLE     = 10;
    localparam int DRAIN_CYCLES = 45;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1846;

    // Expected contents of one result word.
    typedef struct {
        logic signed [16:0] corr_dist;
        logic [5:0]         steps;
        end_reason_t        reason;
        logic [3:0]         row;
        logic [3:0]         col;
    } ray_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0]    pwdata;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic [15:0]              start_x;
    logic [15:0]              start_y;
    logic [ANGLE_W-1:0]       view_angle;
    logic [ANGLE_W-1:0]       ray_angle;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [16:0]       corrected_distance;
    logic [5:0]               step_count;
    logic [1:0]               end_reason;
    logic [3:0]               stop_row;
    logic [3:0]               stop_column;

    // Local copy of the map registers, starting at their reset values.
    logic [4:0]  grid_w = 5'd10;
    logic [4:0]  grid_h = 5'd10;
    logic [63:0] wall_map [4] = '{default: 64'd0};

    int          quarter_table [0:QUARTER];
    ray_result_t pending_rays [$];
    int          max_idle = MAX_IDLE;
    int          failures = 0;
    int          rays_sent = 0;
    int          rays_checked = 0;
    int          map_settings = 1;
    int          reason_tally [3] = '{default: 0};

    grid_ray_march_distance DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .start_x            (start_x),
        .start_y            (start_y),
        .view_angle         (view_angle),
        .ray_angle          (ray_angle),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .corrected_distance (corrected_distance),
        .step_count         (step_count),
        .end_reason         (end_reason),
        .stop_row           (stop_row),
        .stop_column        (stop_column)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Count a failure and report only the first few.
    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Bits 123..60 of a 64 x 64 product, i.e. a Q60 multiply.
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[123:60];
    endfunction

    // One table entry: round(16384 * sin(pi/2 * r / 256)) by a Q60 Taylor series.
    function automatic int quarter_wave(input int unsigned r);
        logic [63:0] low_bits;
        logic [63:0] phase;
        logic [63:0] phase_sq;
        logic [63:0] term;
        logic [63:0] acc;
        low_bits = PI_HALF_Q60 & 64'(QUARTER - 1);
        phase    = (PI_HALF_Q60 >> 8) * 64'(r) + ((low_bits * 64'(r)) >> 8);
        phase_sq = q60_product(phase, phase);
        term     = phase;
        acc      = phase;
        for (int n = 1; n <= 12; n++)
        begin
            term = q60_product(term, phase_sq) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return int'((acc + (64'd1 << 45)) >> 46);
    endfunction

    // Full-turn sine from the quarter-wave table, Q1.14.
    function automatic int sine_at(input int a);
        int quadrant;
        int offset;
        int mag;
        a        = a & ((1 << ANGLE_W) - 1);
        quadrant = a >> 8;
        offset   = a & (QUARTER - 1);
        mag      = (quadrant & 1) ? quarter_table[QUARTER - offset] : quarter_table[offset];
        return (quadrant & 2) ? -mag : mag;
    endfunction

    function automatic int cosine_at(input int a);
        return sine_at(a + QUARTER);
    endfunction

    // March one ray over the current map and work out its result word.
    function automatic ray_result_t march_ray(input logic [15:0] sx, input logic [15:0] sy,
                                              input logic [9:0] va, input logic [9:0] ra);
        int          x;
        int          y;
        int          w;
        int          h;
        int          dx;
        int          dy;
        int          steps;
        int          scaled;
        int          cell_r;
        int          cell_c;
        ray_result_t res;
        x     = int'(sx);
        y     = int'(sy);
        w     = (grid_w < GRID_CELLS) ? int'(grid_w) : GRID_CELLS;
        h     = (grid_h < GRID_CELLS) ? int'(grid_h) : GRID_CELLS;
        dx    = cosine_at(int'(ra)) >>> 2;
        dy    = sine_at(int'(ra)) >>> 2;
        steps = 0;
        res.row = 4'd0;
        res.col = 4'd0;
        // Bounds first, then the wall bit, then the step limit.
        forever
        begin
            if (x < 0 || x >= w * 4096 || y < 0 || y >= h * 4096)
            begin
                res.reason = END_LEFT_MAP;
                break;
            end
            cell_r = (x >> 12) & 15;
            cell_c = (y >> 12) & 15;
            if (wall_map[cell_r / 4][(cell_r % 4) * 16 + cell_c])
            begin
                res.reason = END_WALL_HIT;
                res.row    = 4'(cell_r);
                res.col    = 4'(cell_c);
                break;
            end
            if (steps >= STEP_LIMIT)
            begin
                res.reason = END_STEP_LIMIT;
                break;
            end
            x += dx;
            y += dy;
            steps++;
        end
        // Perspective correction with a floor shift, clamped to 17 bits.
        scaled = (steps * cosine_at(int'(va) - int'(ra))) >>> 4;
        if (scaled > 65535)
        begin
            scaled = 65535;
        end
        if (scaled < -65536)
        begin
            scaled = -65536;
        end
        res.corr_dist = scaled[16:0];
        res.steps     = (steps > 63) ? 6'd63 : 6'(steps);
        return res;
    endfunction

    // Offer one input word after a random gap and queue its expected result.
    task automatic send_ray(input logic [15:0] sx, input logic [15:0] sy,
                            input logic [9:0] va, input logic [9:0] ra);
        int          gap;
        ray_result_t want;
        gap  = $urandom_range(0, max_idle);
        want = march_ray(sx, sy, va, ra);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        start_x    <= sx;
        start_y    <= sy;
        view_angle <= va;
        ray_angle  <= ra;
        do
            @(posedge clk);
        while (in_stall);
        pending_rays.push_back(want);
        rays_sent++;
    endtask

    // Drop valid and wait for every outstanding result word.
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rays.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rays.size() != 0)
        begin
            note_failure($sformatf("%0d result words never arrived", pending_rays.size()));
            pending_rays.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  grid_w = value[4:0];
            REG_GRID_HEIGHT: grid_h = value[4:0];
            default:         wall_map[int'(idx) - int'(REG_WALL_0)] = value;
        endcase
    endtask

    // Load a whole map while the block is idle.
    task automatic load_map(input logic [4:0] w, input logic [4:0] h,
                            input logic [63:0] r0, input logic [63:0] r1,
                            input logic [63:0] r2, input logic [63:0] r3);
        wait_idle();
        write_reg(REG_GRID_WIDTH, 64'(w));
        write_reg(REG_GRID_HEIGHT, 64'(h));
        write_reg(REG_WALL_0, r0);
        write_reg(REG_WALL_1, r1);
        write_reg(REG_WALL_2, r2);
        write_reg(REG_WALL_3, r3);
        map_settings++;
    endtask

    // Mostly sparse walls so that rays travel far; now and then empty or solid.
    function automatic logic [63:0] random_wall_bits();
        logic [63:0] bits;
        int          thin;
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            default:
            begin
                bits = {$urandom, $urandom};
                thin = $urandom_range(1, 4);
                repeat (thin) bits &= {$urandom, $urandom};
                return bits;
            end
        endcase
    endfunction

    // Map bounds weighted toward the legal range, with zero and oversize now and then.
    function automatic logic [4:0] random_bound();
        case ($urandom_range(0, 9))
            0:       return 5'($urandom_range(0, 3));
            1:       return 5'($urandom_range(17, 31));
            2:       return 5'd16;
            default: return 5'($urandom_range(4, 16));
        endcase
    endfunction

    // Start coordinate, usually inside the map so that the march gets going.
    function automatic logic [15:0] random_coord(input logic [4:0] bound);
        int cells;
        cells = (bound < GRID_CELLS) ? int'(bound) : GRID_CELLS;
        if (cells > 0 && $urandom_range(0, 9) < 8)
        begin
            return 16'($urandom_range(0, cells * 4096 - 1));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Reset map: 10 x 10, no walls.
    task automatic test_reset_defaults();
        // Along +x from the origin the ray leaves the map after ten steps.
        send_ray(16'h0000, 16'h0000, 10'd0, 10'd0);
        // Half a turn between view and ray gives a negative distance.
        send_ray(16'h4800, 16'h4800, 10'd512, 10'd0);
        // A quarter turn gives a zero correction factor.
        send_ray(16'h4800, 16'h4800, 10'd256, 10'd0);
        // Top corner lies outside the reset map.
        send_ray(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023);
    endtask

    // Open 16 x 16 map: every octant from the center.
    task automatic test_axis_rays();
        load_map(5'd16, 5'd16, 64'd0, 64'd0, 64'd0, 64'd0);
        for (int k = 0; k < 8; k++)
        begin
            send_ray(16'h8000, 16'h8000, 10'(k * 200), 10'(k * 128));
        end
        send_ray(16'h8000, 16'h8000, 10'd0, 10'd1023);
    endtask

    // Wall hits: far corner, hit at the start cell, solid map.
    task automatic test_wall_hits();
        load_map(5'd16, 5'd16, 64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
        send_ray(16'h0000, 16'h0000, 10'd128, 10'd128);
        send_ray(16'hFFFF, 16'hFFFF, 10'd0, 10'd0);
        load_map(5'd16, 5'd16, '1, '1, '1, '1);
        send_ray(16'h1234, 16'hABCD, 10'd300, 10'd700);
    endtask

    // Zero, minimal and oversize bounds.
    task automatic test_map_bounds();
        load_map(5'd0, 5'd16, 64'd0, 64'd0, 64'd0, 64'd0);
        send_ray(16'h0000, 16'h8000, 10'd0, 10'd0);
        load_map(5'd16, 5'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_ray(16'h8000, 16'h0000, 10'd0, 10'd0);
        load_map(5'd31, 5'd31, 64'd0, 64'd0, 64'd0, 64'd0);
        send_ray(16'h0000, 16'h0000, 10'd128, 10'd128);
        send_ray(16'hFFFF, 16'hFFFF, 10'd0, 10'd512);
        load_map(5'd1, 5'd1, 64'd0, 64'd0, 64'd0, 64'd0);
        send_ray(16'h0800, 16'h0800, 10'd0, 10'd0);
    endtask

    // Random maps with random rays; a few phases run with no idling at all.
    task automatic test_random_maps();
        for (int phase = 0; phase < 14; phase++)
        begin
            load_map(random_bound(), random_bound(), random_wall_bits(), random_wall_bits(),
                     random_wall_bits(), random_wall_bits());
            max_idle = (phase % 5 == 3) ? 0 : MAX_IDLE;
            repeat (100)
            begin
                send_ray(random_coord(grid_w), random_coord(grid_h),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
        end
        max_idle = MAX_IDLE;
    endtask

    // Receiver: random stall before each word, then compare with the oldest expectation.
    initial
    begin : result_monitor
        int          stall_cycles;
        ray_result_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_cycles = $urandom_range(0, max_idle);
            if (stall_cycles > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (pending_rays.size() == 0)
            begin
                note_failure("result word arrived with no ray outstanding");
            end
            else
            begin
                want = pending_rays.pop_front();
                rays_checked++;
                reason_tally[int'(want.reason)]++;
                if (corrected_distance !== want.corr_dist || step_count !== want.steps ||
                    end_reason !== want.reason || stop_row !== want.row ||
                    stop_column !== want.col)
                begin
                    note_failure($sformatf({"ray %0d: expected dist %0d steps %0d reason %0d",
                        " cell %0d,%0d; got dist %0d steps %0d reason %0d cell %0d,%0d"},
                        rays_checked, want.corr_dist, want.steps, want.reason, want.row,
                        want.col, corrected_distance, step_count, end_reason, stop_row,
                        stop_column));
                end
            end
        end
    end

    // Main sequence.
    initial
    begin : test_sequence
        for (int r = 0; r <= QUARTER; r++)
        begin
            quarter_table[r] = quarter_wave(r);
        end
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        start_x    = '0;
        start_y    = '0;
        view_angle = '0;
        ray_angle  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_axis_rays();
        test_wall_hits();
        test_map_bounds();
        test_random_maps();

        // Let the last words drain, then watch for strays.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Marched %0d rays over %0d map settings, %0d result words checked.",
                 rays_sent, map_settings, rays_checked);
        $display("Rays left the map %0d times, hit a wall %0d times, hit the limit %0d times.",
                 reason_tally[0], reason_tally[1], reason_tally[2]);
        if (failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
